FILE: design/tmm_pkg.sv
// shared types and constants for the trs model matrix block
package tmm_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] angle_x;
    logic signed [23:0] angle_y;
    logic signed [23:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] tr_x;
    logic signed [31:0] tr_y;
    logic signed [31:0] tr_z;
  } res_t;

  localparam int unsigned CordicIters = 16;
  localparam int unsigned DegFrac = 16;
  localparam logic signed [32:0] CordicInit = 33'sd652032874;

  localparam logic signed [26:0] AtanDeg [CordicIters] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379, 27'sd117304, 27'sd58666, 27'sd29335,
    27'sd14668, 27'sd7334, 27'sd3667, 27'sd1833,
    27'sd917, 27'sd458, 27'sd229, 27'sd115
  };

endpackage

FILE: design/trs_model_matrix.sv
// trs model matrix: pipelined euler xyz rotation, scale and translation
// One transform enters every cycle (busy_o is always low) and its matrix appears
// for one cycle on res_o, marked by valid_o, after two angle reduction stages,
// sixteen cordic stages, one sign stage, two product stages, one scale multiply
// stage and the output register. The receiver cannot stall, so results must be
// taken when valid_o is high.
module trs_model_matrix #(
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  tmm_pkg::in_t    in_i,
  output logic            busy_o,
  output logic            valid_o,
  output tmm_pkg::res_t   res_o
);

  localparam int unsigned Lat = 23;
  localparam int unsigned DlDepth = 22;
  localparam int unsigned Iters = tmm_pkg::CordicIters;
  localparam longint Period = longint'(360) << ANGLE_FRAC_BITS;
  localparam longint KOff = ((longint'(1) << 23) + Period - 1) / Period;
  localparam longint Recip = (longint'(1) << 40) / Period;
  localparam logic [24:0] OffV = 25'(KOff * Period);
  localparam logic [27:0] RecipV = 28'(Recip);
  localparam logic [24:0] PeriodV = 25'(Period);
  localparam logic signed [26:0] Half = 27'sd180 <<< tmm_pkg::DegFrac;
  localparam logic signed [26:0] Quarter = 27'sd90 <<< tmm_pkg::DegFrac;
  localparam logic signed [26:0] Full = 27'sd360 <<< tmm_pkg::DegFrac;

  function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = (p + 66'sd536870912) >>> 30;
    return t[35:0];
  endfunction

  logic [Lat-1:0] vld_q;
  tmm_pkg::in_t   dl_q [DlDepth];

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q[0] <= in_i;
    for (int k = 1; k < DlDepth; k++) begin
      dl_q[k] <= dl_q[k-1];
    end
  end

  // angle reduction
  logic signed [23:0] ang [3];
  assign ang[0] = in_i.angle_x;
  assign ang[1] = in_i.angle_y;
  assign ang[2] = in_i.angle_z;

  logic [24:0]        u_q [3];
  logic [12:0]        q_q [3];
  logic signed [32:0] x_q [3][Iters+1];
  logic signed [32:0] y_q [3][Iters+1];
  logic signed [26:0] z_q [3][Iters+1];
  logic               neg_q [3][Iters+1];

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      logic [24:0] u;
      logic [52:0] prod;
      u = 25'(signed'({ang[a][23], ang[a]})) + OffV;
      prod = 53'(u) * 53'(RecipV);
      u_q[a] <= u;
      q_q[a] <= prod[52:40];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      logic [37:0] qp;
      logic [24:0] r;
      logic signed [26:0] z;
      logic n;
      qp = 38'(q_q[a]) * 38'(PeriodV);
      r = u_q[a] - qp[24:0];
      if (r >= PeriodV) begin
        r = r - PeriodV;
      end
      z = signed'(27'(r) << (tmm_pkg::DegFrac - ANGLE_FRAC_BITS));
      n = 1'b0;
      if (z > Half) begin
        z = z - Full;
      end
      if (z > Quarter) begin
        z = z - Half;
        n = 1'b1;
      end else if (z < -Quarter) begin
        z = z + Half;
        n = 1'b1;
      end
      x_q[a][0] <= tmm_pkg::CordicInit;
      y_q[a][0] <= '0;
      z_q[a][0] <= z;
      neg_q[a][0] <= n;
    end
    // cordic, one iteration per stage
    for (int s = 0; s < Iters; s++) begin
      for (int a = 0; a < 3; a++) begin
        if (!z_q[a][s][26]) begin
          x_q[a][s+1] <= x_q[a][s] - (y_q[a][s] >>> s);
          y_q[a][s+1] <= y_q[a][s] + (x_q[a][s] >>> s);
          z_q[a][s+1] <= z_q[a][s] - tmm_pkg::AtanDeg[s];
        end else begin
          x_q[a][s+1] <= x_q[a][s] + (y_q[a][s] >>> s);
          y_q[a][s+1] <= y_q[a][s] - (x_q[a][s] >>> s);
          z_q[a][s+1] <= z_q[a][s] + tmm_pkg::AtanDeg[s];
        end
        neg_q[a][s+1] <= neg_q[a][s];
      end
    end
  end

  // quadrant sign
  logic signed [32:0] sin_q [3];
  logic signed [32:0] cos_q [3];

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      sin_q[a] <= neg_q[a][Iters] ? -y_q[a][Iters] : y_q[a][Iters];
      cos_q[a] <= neg_q[a][Iters] ? -x_q[a][Iters] : x_q[a][Iters];
    end
  end

  // first products
  logic signed [35:0] sxsy_q, cxsy_q, cycz_q, cysz_q, cxsz_q, cxcz_q, sxcy_q, sxsz_q, cxcy_q;
  logic signed [35:0] sxcz_q;
  logic signed [35:0] sy_p_q, sz_p_q, cz_p_q;

  always_ff @(posedge clk_i) begin
    sxsy_q <= rnd30(66'(sin_q[0]) * 66'(sin_q[1]));
    cxsy_q <= rnd30(66'(cos_q[0]) * 66'(sin_q[1]));
    cycz_q <= rnd30(66'(cos_q[1]) * 66'(cos_q[2]));
    cysz_q <= rnd30(66'(cos_q[1]) * 66'(sin_q[2]));
    cxsz_q <= rnd30(66'(cos_q[0]) * 66'(sin_q[2]));
    cxcz_q <= rnd30(66'(cos_q[0]) * 66'(cos_q[2]));
    sxcy_q <= rnd30(66'(sin_q[0]) * 66'(cos_q[1]));
    sxsz_q <= rnd30(66'(sin_q[0]) * 66'(sin_q[2]));
    cxcy_q <= rnd30(66'(cos_q[0]) * 66'(cos_q[1]));
    sxcz_q <= rnd30(66'(sin_q[0]) * 66'(cos_q[2]));
    sy_p_q <= 36'(sin_q[1]);
    sz_p_q <= 36'(sin_q[2]);
    cz_p_q <= 36'(cos_q[2]);
  end

  // rotation elements
  logic signed [35:0] e_q [9];

  always_ff @(posedge clk_i) begin
    e_q[0] <= cycz_q;
    e_q[1] <= -cysz_q;
    e_q[2] <= sy_p_q;
    e_q[3] <= rnd30(66'(sxsy_q) * 66'(cz_p_q)) + cxsz_q;
    e_q[4] <= cxcz_q - rnd30(66'(sxsy_q) * 66'(sz_p_q));
    e_q[5] <= -sxcy_q;
    e_q[6] <= sxsz_q - rnd30(66'(cxsy_q) * 66'(cz_p_q));
    e_q[7] <= rnd30(66'(cxsy_q) * 66'(sz_p_q)) + sxcz_q;
    e_q[8] <= cxcy_q;
  end

  // scaling
  logic signed [67:0] sp_q [9];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      logic signed [31:0] sc;
      case (i % 3)
        0:       sc = dl_q[20].scale_x;
        1:       sc = dl_q[20].scale_y;
        default: sc = dl_q[20].scale_z;
      endcase
      sp_q[i] <= 68'(e_q[i]) * 68'(sc);
    end
  end

  // round, saturate and output
  logic signed [31:0] m_d [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      logic signed [67:0] t;
      t = (sp_q[i] + 68'sd536870912) >>> 30;
      if (t > 68'sd2147483647) begin
        m_d[i] = 32'sh7fffffff;
      end else if (t < -68'sd2147483648) begin
        m_d[i] = 32'sh80000000;
      end else begin
        m_d[i] = t[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.m00  <= m_d[0];
    res_o.m01  <= m_d[1];
    res_o.m02  <= m_d[2];
    res_o.m10  <= m_d[3];
    res_o.m11  <= m_d[4];
    res_o.m12  <= m_d[5];
    res_o.m20  <= m_d[6];
    res_o.m21  <= m_d[7];
    res_o.m22  <= m_d[8];
    res_o.tr_x <= dl_q[21].pos_x;
    res_o.tr_y <= dl_q[21].pos_y;
    res_o.tr_z <= dl_q[21].pos_z;
  end

  assign valid_o = vld_q[Lat-1];

endmodule

FILE: tb/tb.sv
// testbench for trs_model_matrix: directed table plus random transforms against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AngleFrac = 8;
  localparam int unsigned Latency = 23;
  localparam int unsigned NumRandom = 1930;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  tmm_pkg::in_t in_i;
  logic busy_o;
  logic valid_o;
  tmm_pkg::res_t res_o;

  tmm_pkg::res_t matrix_q[$];
  int errors;
  int checked;
  int sat_hits;

  trs_model_matrix #(.ANGLE_FRAC_BITS(AngleFrac)) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .in_i(in_i),
    .busy_o(busy_o),
    .valid_o(valid_o),
    .res_o(res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rot_mul(longint a, longint b);
    return floor_shift(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic void angle_sincos(input logic signed [23:0] ang, output longint s,
                                       output longint c);
    longint period, r, z, x, y, dx, dy, half, quarter;
    bit flip;
    period = 64'sd360 <<< AngleFrac;
    r = longint'(ang) % period;
    if (r < 0) r += period;
    z = r <<< (tmm_pkg::DegFrac - AngleFrac);
    half = 64'sd180 <<< tmm_pkg::DegFrac;
    quarter = 64'sd90 <<< tmm_pkg::DegFrac;
    flip = 1'b0;
    if (z > half) z -= 2 * half;
    if (z > quarter) begin
      z -= half;
      flip = 1'b1;
    end else if (z < -quarter) begin
      z += half;
      flip = 1'b1;
    end
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(tmm_pkg::AtanDeg[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(tmm_pkg::AtanDeg[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic logic signed [31:0] scale_clamp(longint e, logic signed [31:0] sc);
    longint v;
    v = floor_shift(e * longint'(sc) + (64'sd1 <<< 29), 30);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic tmm_pkg::res_t model_matrix(tmm_pkg::in_t t);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    longint e[9];
    logic signed [31:0] m[9];
    tmm_pkg::res_t r;
    angle_sincos(t.angle_x, sx, cx);
    angle_sincos(t.angle_y, sy, cy);
    angle_sincos(t.angle_z, sz, cz);
    sxsy = rot_mul(sx, sy);
    cxsy = rot_mul(cx, sy);
    e[0] = rot_mul(cy, cz);
    e[1] = -rot_mul(cy, sz);
    e[2] = sy;
    e[3] = rot_mul(sxsy, cz) + rot_mul(cx, sz);
    e[4] = rot_mul(cx, cz) - rot_mul(sxsy, sz);
    e[5] = -rot_mul(sx, cy);
    e[6] = rot_mul(sx, sz) - rot_mul(cxsy, cz);
    e[7] = rot_mul(cxsy, sz) + rot_mul(sx, cz);
    e[8] = rot_mul(cx, cy);
    for (int i = 0; i < 9; i++)
      m[i] = scale_clamp(e[i], (i % 3 == 0) ? t.scale_x :
                               (i % 3 == 1) ? t.scale_y : t.scale_z);
    r = '{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8],
          t.pos_x, t.pos_y, t.pos_z};
    return r;
  endfunction

  function automatic logic signed [23:0] pick_angle();
    case ($urandom_range(0, 4))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 720 * 256)) - 24'sd184320;
      2: return 24'(($urandom_range(0, 8)) * 90 * 256) - 24'sd92160;
      default: return 24'($urandom_range(0, 360 * 256));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 32'($urandom);
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'($urandom_range(0, 1 << 20)) - 32'sd524288;
    endcase
  endfunction

  // one transfer, with the expected matrix queued at acceptance
  task automatic send(tmm_pkg::in_t t, bit has_exp, tmm_pkg::res_t exp_r);
    start_i <= 1'b1;
    in_i <= t;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (has_exp && exp_r !== model_matrix(t)) begin
      $display("%0t directed row disagrees with predictor: exp %h act %h", $time,
               exp_r, model_matrix(t));
      errors++;
    end
    matrix_q.push_back(has_exp ? exp_r : model_matrix(t));
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    if (n == 0) return;
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (matrix_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, res_o);
        errors++;
      end else begin
        tmm_pkg::res_t e;
        e = matrix_q.pop_front();
        checked++;
        if (e.m00 == 32'sh7fffffff || e.m00 == 32'sh80000000) sat_hits++;
        if (e !== res_o) begin
          errors++;
          $display("%0t mismatch m: exp %h %h %h %h %h %h %h %h %h", $time,
                   e.m00, e.m01, e.m02, e.m10, e.m11, e.m12, e.m20, e.m21, e.m22);
          $display("%0t mismatch m: act %h %h %h %h %h %h %h %h %h", $time,
                   res_o.m00, res_o.m01, res_o.m02, res_o.m10, res_o.m11, res_o.m12,
                   res_o.m20, res_o.m21, res_o.m22);
          $display("%0t mismatch tr: exp %h %h %h act %h %h %h", $time,
                   e.tr_x, e.tr_y, e.tr_z, res_o.tr_x, res_o.tr_y, res_o.tr_z);
        end
      end
    end
  end

  typedef struct {
    tmm_pkg::in_t stim;
    bit has_exp;
    tmm_pkg::res_t exp_r;
  } row_t;

  initial begin
    row_t rows[$];
    tmm_pkg::in_t t;
    tmm_pkg::res_t r0;
    int wait_cycles;
    errors = 0;
    checked = 0;
    sat_hits = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero scale: matrix all zero, translation passes through
    r0 = '0;
    t = '{32'sh7fffffff, 32'sh80000000, 32'sd0, 24'sd0, 24'sd0, 24'sd0, 0, 0, 0};
    r0.tr_x = 32'sh7fffffff;
    r0.tr_y = 32'sh80000000;
    rows.push_back('{t, 1'b1, r0});
    t = '{32'sh80000000, 32'shffffffff, 32'sh7fffffff, 24'sh7fffff, 24'sh800000,
          24'shffffff, 0, 0, 0};
    r0 = '0;
    r0.tr_x = 32'sh80000000;
    r0.tr_y = 32'shffffffff;
    r0.tr_z = 32'sh7fffffff;
    rows.push_back('{t, 1'b1, r0});
    for (int k = 0; k < 20; k++) begin
      t.pos_x = 32'($urandom);
      t.pos_y = 32'($urandom);
      t.pos_z = 32'($urandom);
      t.angle_x = (k < 8) ? 24'(k * 90 * 256) : (k < 12) ? -24'((k - 7) * 90 * 256) :
                  (k == 12) ? 24'sh7fffff : (k == 13) ? 24'sh800000 : pick_angle();
      t.angle_y = (k < 8) ? 24'(((k + 3) % 8) * 45 * 256) : (k == 14) ? 24'sh800000 :
                  pick_angle();
      t.angle_z = (k < 8) ? -24'(k * 45 * 256) : (k == 15) ? 24'sh7fffff : pick_angle();
      t.scale_x = (k % 4 == 0) ? 32'sh7fffffff : (k % 4 == 1) ? 32'sh80000000 : 32'sd65536;
      t.scale_y = (k % 3 == 0) ? 32'sh80000000 : (k % 3 == 1) ? 32'sh7fffffff : -32'sd65536;
      t.scale_z = (k % 2 == 0) ? 32'sh7fffffff : 32'sh80000000;
      rows.push_back('{t, 1'b0, '0});
    end
    foreach (rows[i]) begin
      send(rows[i].stim, rows[i].has_exp, rows[i].exp_r);
      idle_gap();
    end

    for (int n = 0; n < NumRandom; n++) begin
      t.pos_x = 32'($urandom);
      t.pos_y = 32'($urandom);
      t.pos_z = 32'($urandom);
      t.angle_x = pick_angle();
      t.angle_y = pick_angle();
      t.angle_z = pick_angle();
      t.scale_x = pick_scale();
      t.scale_y = pick_scale();
      t.scale_z = pick_scale();
      send(t, 1'b0, '0);
      if (n == NumRandom / 2) begin
        start_i <= 1'b0;
        while (matrix_q.size() != 0) @(posedge clk_i);
      end else if (n > 300 && n < 500) begin
        // back-to-back stretch
      end else begin
        idle_gap();
      end
    end
    start_i <= 1'b0;

    wait_cycles = 0;
    while (matrix_q.size() != 0 && wait_cycles < 10 * Latency + 100) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (Latency + 5) @(posedge clk_i);
    if (matrix_q.size() != 0) errors++;
    $display("covered %0d transforms with wrapped, right and random angles", checked);
    $display("and extreme scales, %0d results with a clamped first element", sat_hits);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
